/* hdl/bhp_pkg.sv */
// Shared constants, types and character tables for the backup header parser.
`timescale 1ns / 1ps
`default_nettype none
package bhp_pkg;

    // Number of leading file bytes that are examined
    localparam int HEAD_CAP  = 4096;
    localparam int POS_W     = $clog2(HEAD_CAP + 1);
    localparam int OFF_W     = 13;
    localparam int MAGIC_LEN = 15;
    localparam int VER_W     = 31;
    localparam int NONE_LEN  = 4;
    localparam int AES_LEN   = 17;
    localparam int MLEN_W    = 5;

    localparam logic [VER_W-1:0] VER_MAX = {VER_W{1'b1}};
    localparam logic [7:0]       CH_LF    = 8'h0A;
    localparam logic [7:0]       CH_MINUS = 8'h2D;
    localparam logic [7:0]       CH_ZERO  = 8'h30;
    localparam logic [7:0]       CH_ONE   = 8'h31;
    localparam logic [7:0]       CH_NINE  = 8'h39;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_MAGIC = 3'd1;
    localparam logic [2:0] ST_MISSING  = 3'd2;
    localparam logic [2:0] ST_BAD_VER  = 3'd3;
    localparam logic [2:0] ST_BAD_COMP = 3'd4;

    // Encryption codes
    localparam logic [1:0] ENC_NONE    = 2'd0;
    localparam logic [1:0] ENC_AES     = 2'd1;
    localparam logic [1:0] ENC_UNKNOWN = 2'd2;

    // Fixed offset of the earliest possible ok payload
    localparam int MIN_OK_OFFSET = 20;

    typedef struct packed {
        logic [2:0]       status;
        logic [VER_W-1:0] version;
        logic             compression;
        logic [1:0]       encryption;
        logic [OFF_W-1:0] payload_offset;
    } t_result;

    // Magic line, one byte per index
    function automatic logic [7:0] magic_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h41; // A
            4'd1:    ch = 8'h4E; // N
            4'd2:    ch = 8'h44; // D
            4'd3:    ch = 8'h52; // R
            4'd4:    ch = 8'h4F; // O
            4'd5:    ch = 8'h49; // I
            4'd6:    ch = 8'h44; // D
            4'd7:    ch = 8'h20; // space
            4'd8:    ch = 8'h42; // B
            4'd9:    ch = 8'h41; // A
            4'd10:   ch = 8'h43; // C
            4'd11:   ch = 8'h4B; // K
            4'd12:   ch = 8'h55; // U
            4'd13:   ch = 8'h50; // P
            4'd14:   ch = 8'h0A; // newline
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Marker text "none"
    function automatic logic [7:0] none_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h6E;
            2'd1:    ch = 8'h6F;
            2'd2:    ch = 8'h6E;
            2'd3:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Marker text "AES-256-encrypted"
    function automatic logic [7:0] aes_char(input logic [MLEN_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = 8'h41; // A
            5'd1:    ch = 8'h45; // E
            5'd2:    ch = 8'h53; // S
            5'd3:    ch = 8'h2D; // -
            5'd4:    ch = 8'h32; // 2
            5'd5:    ch = 8'h35; // 5
            5'd6:    ch = 8'h36; // 6
            5'd7:    ch = 8'h2D; // -
            5'd8:    ch = 8'h65; // e
            5'd9:    ch = 8'h6E; // n
            5'd10:   ch = 8'h63; // c
            5'd11:   ch = 8'h72; // r
            5'd12:   ch = 8'h79; // y
            5'd13:   ch = 8'h70; // p
            5'd14:   ch = 8'h74; // t
            5'd15:   ch = 8'h65; // e
            5'd16:   ch = 8'h64; // d
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

/* hdl/bhp_core.sv */
// Per-byte parse state and result formation for the backup header parser.
`timescale 1ns / 1ps
`default_nettype none
module bhp_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_last_byte,
    output logic                 o_emit,
    output bhp_pkg::t_result     o_result
);
    import bhp_pkg::*;

    // Phase codes
    localparam logic [2:0] PH_SEARCH  = 3'd0;
    localparam logic [2:0] PH_VERSION = 3'd1;
    localparam logic [2:0] PH_COMP    = 3'd2;
    localparam logic [2:0] PH_MARKER  = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    // Compression line codes
    localparam logic [1:0] CS_EMPTY = 2'd0;
    localparam logic [1:0] CS_ZERO  = 2'd1;
    localparam logic [1:0] CS_ONE   = 2'd2;
    localparam logic [1:0] CS_OTHER = 2'd3;

    localparam int EXT_W  = (POS_W > OFF_W) ? POS_W : OFF_W;
    localparam int PROD_W = VER_W + 4;

    logic [7:0]        r_recent [MAGIC_LEN];
    logic [7:0]        n_recent [MAGIC_LEN];
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [2:0]        r_phase, n_phase;
    logic [VER_W-1:0]  r_acc, n_acc;
    logic              r_vf_digit, n_vf_digit;
    logic              r_vf_minus, n_vf_minus;
    logic              r_vf_bad, n_vf_bad;
    logic              r_vf_any, n_vf_any;
    logic [1:0]        r_comp, n_comp;
    logic [MLEN_W-1:0] r_mlen, n_mlen;
    logic              r_m_none, n_m_none;
    logic              r_m_aes, n_m_aes;
    logic              r_sent, n_sent;

    logic              w_in_cap;
    logic              w_magic_hit;
    logic [PROD_W-1:0] w_prod;
    logic              w_ver_ok;
    logic [EXT_W-1:0]  w_off_ext;
    logic [1:0]        w_enc;

    assign w_in_cap = r_pos < POS_W'(HEAD_CAP);

    // Next version value: acc * 10 + digit
    assign w_prod = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0}
                  + PROD_W'(i_data_byte - CH_ZERO);

    assign w_ver_ok = !r_vf_bad && r_vf_digit && !(r_vf_minus && (r_acc != '0));

    assign w_off_ext = EXT_W'(r_pos) + EXT_W'(1);

    // Classify the marker line
    always_comb begin
        if (r_m_none && (r_mlen == MLEN_W'(NONE_LEN))) begin
            w_enc = ENC_NONE;
        end else if (r_m_aes && (r_mlen == MLEN_W'(AES_LEN))) begin
            w_enc = ENC_AES;
        end else begin
            w_enc = ENC_UNKNOWN;
        end
    end

    // Shifted window and magic compare
    always_comb begin
        for (int i = 0; i < MAGIC_LEN - 1; i++) begin
            n_recent[i] = r_recent[i];
        end
        n_recent[MAGIC_LEN-1] = r_recent[MAGIC_LEN-1];
        w_magic_hit = 1'b1;
        for (int i = 0; i < MAGIC_LEN - 1; i++) begin
            if (r_recent[i+1] != magic_char(4'(i))) begin
                w_magic_hit = 1'b0;
            end
        end
        if (i_data_byte != magic_char(4'(MAGIC_LEN - 1))) begin
            w_magic_hit = 1'b0;
        end
        if (i_step && w_in_cap && (r_phase == PH_SEARCH)) begin
            for (int i = 0; i < MAGIC_LEN - 1; i++) begin
                n_recent[i] = r_recent[i+1];
            end
            n_recent[MAGIC_LEN-1] = i_data_byte;
        end
        if (i_step && i_last_byte) begin
            for (int i = 0; i < MAGIC_LEN; i++) begin
                n_recent[i] = 8'h00;
            end
        end
    end

    // Advance the line parser by one item
    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_vf_digit = r_vf_digit;
        n_vf_minus = r_vf_minus;
        n_vf_bad   = r_vf_bad;
        n_vf_any   = r_vf_any;
        n_comp     = r_comp;
        n_mlen     = r_mlen;
        n_m_none   = r_m_none;
        n_m_aes    = r_m_aes;
        n_sent     = r_sent;
        o_emit     = 1'b0;
        o_result   = '0;

        if (i_step && w_in_cap) begin
            n_pos = r_pos + POS_W'(1);
            case (r_phase)
                PH_SEARCH: begin
                    if (w_magic_hit) begin
                        n_phase    = PH_VERSION;
                        n_acc      = '0;
                        n_vf_digit = 1'b0;
                        n_vf_minus = 1'b0;
                        n_vf_bad   = 1'b0;
                        n_vf_any   = 1'b0;
                        n_comp     = CS_EMPTY;
                        n_mlen     = '0;
                        n_m_none   = 1'b1;
                        n_m_aes    = 1'b1;
                    end
                end
                PH_VERSION: begin
                    if (i_data_byte == CH_LF) begin
                        n_phase = PH_COMP;
                    end else begin
                        n_vf_any = 1'b1;
                        if ((i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE)) begin
                            n_vf_digit = 1'b1;
                            if (w_prod > PROD_W'(VER_MAX)) begin
                                n_vf_bad = 1'b1;
                            end else begin
                                n_acc = w_prod[VER_W-1:0];
                            end
                        end else if ((i_data_byte == CH_MINUS) && !r_vf_any) begin
                            n_vf_minus = 1'b1;
                        end else begin
                            n_vf_bad = 1'b1;
                        end
                    end
                end
                PH_COMP: begin
                    if (i_data_byte == CH_LF) begin
                        n_phase = PH_MARKER;
                    end else if ((r_comp == CS_EMPTY) && (i_data_byte == CH_ZERO)) begin
                        n_comp = CS_ZERO;
                    end else if ((r_comp == CS_EMPTY) && (i_data_byte == CH_ONE)) begin
                        n_comp = CS_ONE;
                    end else begin
                        n_comp = CS_OTHER;
                    end
                end
                PH_MARKER: begin
                    if (i_data_byte == CH_LF) begin
                        n_phase = PH_DONE;
                        n_sent  = 1'b1;
                        o_emit  = 1'b1;
                        if (!w_ver_ok) begin
                            o_result.status = ST_BAD_VER;
                        end else if ((r_comp != CS_ZERO) && (r_comp != CS_ONE)) begin
                            o_result.status = ST_BAD_COMP;
                        end else begin
                            o_result.status         = ST_OK;
                            o_result.version        = r_acc;
                            o_result.compression    = (r_comp == CS_ONE);
                            o_result.encryption     = w_enc;
                            o_result.payload_offset = w_off_ext[OFF_W-1:0];
                        end
                    end else begin
                        // Drop a candidate on the first mismatch
                        if (r_m_none && !((r_mlen < MLEN_W'(NONE_LEN))
                                && (none_char(r_mlen[1:0]) == i_data_byte))) begin
                            n_m_none = 1'b0;
                        end
                        if (r_m_aes && !((r_mlen < MLEN_W'(AES_LEN))
                                && (aes_char(r_mlen) == i_data_byte))) begin
                            n_m_aes = 1'b0;
                        end
                        if (r_mlen != {MLEN_W{1'b1}}) begin
                            n_mlen = r_mlen + MLEN_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // End of file: report if nothing was reported, then start over
        if (i_step && i_last_byte) begin
            if (!n_sent) begin
                o_emit          = 1'b1;
                o_result        = '0;
                o_result.status = (n_phase == PH_SEARCH) ? ST_NO_MAGIC : ST_MISSING;
            end
            n_pos      = '0;
            n_phase    = PH_SEARCH;
            n_acc      = '0;
            n_vf_digit = 1'b0;
            n_vf_minus = 1'b0;
            n_vf_bad   = 1'b0;
            n_vf_any   = 1'b0;
            n_comp     = CS_EMPTY;
            n_mlen     = '0;
            n_m_none   = 1'b1;
            n_m_aes    = 1'b1;
            n_sent     = 1'b0;
        end
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAGIC_LEN; i++) begin
                r_recent[i] <= 8'h00;
            end
            r_pos      <= '0;
            r_phase    <= PH_SEARCH;
            r_acc      <= '0;
            r_vf_digit <= 1'b0;
            r_vf_minus <= 1'b0;
            r_vf_bad   <= 1'b0;
            r_vf_any   <= 1'b0;
            r_comp     <= CS_EMPTY;
            r_mlen     <= '0;
            r_m_none   <= 1'b1;
            r_m_aes    <= 1'b1;
            r_sent     <= 1'b0;
        end else begin
            for (int i = 0; i < MAGIC_LEN; i++) begin
                r_recent[i] <= n_recent[i];
            end
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_vf_digit <= n_vf_digit;
            r_vf_minus <= n_vf_minus;
            r_vf_bad   <= n_vf_bad;
            r_vf_any   <= n_vf_any;
            r_comp     <= n_comp;
            r_mlen     <= n_mlen;
            r_m_none   <= n_m_none;
            r_m_aes    <= n_m_aes;
            r_sent     <= n_sent;
        end
    end

endmodule
`default_nettype wire

/* hdl/backup_header_parser.sv */
// Top level of the backup header parser: handshake and result register.
//
// Takes a file one byte per item and gives one result item per file: on the
// newline that closes the third header line after the magic line, or else on
// the item flagged as the last byte. Only the first HEAD_CAP bytes are parsed;
// later bytes only act through their last-byte flag. One item per clock is
// sustained; the input stalls only while the result register is full and the
// output side stalls. A result is registered and appears on the output in the
// cycle after the byte that causes it.
`timescale 1ns / 1ps
`default_nettype none
module backup_header_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [7:0]                 i_data_byte,
    input  wire logic                       i_last_byte,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [2:0]                      o_status,
    output logic [bhp_pkg::VER_W-1:0]       o_version,
    output logic                            o_compression,
    output logic [1:0]                      o_encryption,
    output logic [bhp_pkg::OFF_W-1:0]       o_payload_offset
);
    import bhp_pkg::*;

    logic    w_accept;
    logic    w_emit;
    t_result w_result;
    logic    r_out_valid, n_out_valid;
    t_result r_out;

    // Take an item unless a waiting result cannot move
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    bhp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_emit      (w_emit),
        .o_result    (w_result)
    );

    // Load a new result or drop the one just taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept && w_emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_version        = r_out.version;
    assign o_compression    = r_out.compression;
    assign o_encryption     = r_out.encryption;
    assign o_payload_offset = r_out.payload_offset;

endmodule
`default_nettype wire

/* hdl/bhp_checker.sv */
// Port-level checks for the backup header parser and their binding.
`timescale 1ns / 1ps
`default_nettype none
module bhp_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       o_stall,
    input  wire logic                       o_valid,
    input  wire logic                       i_stall,
    input  wire logic [2:0]                 o_status,
    input  wire logic [bhp_pkg::VER_W-1:0]  o_version,
    input  wire logic                       o_compression,
    input  wire logic [1:0]                 o_encryption,
    input  wire logic [bhp_pkg::OFF_W-1:0]  o_payload_offset
);
    import bhp_pkg::*;

    // No result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result dropped");

    // Input stalls only behind a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    // Failed headers carry all-zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |->
            (o_version == '0) && !o_compression && (o_encryption == ENC_NONE)
            && (o_payload_offset == '0))
        else $error("failed result has nonzero fields");

    // An ok header ends no earlier than the shortest legal header and never has encryption code 3
    a_ok_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_OK) |->
            (o_payload_offset >= OFF_W'(MIN_OK_OFFSET)) && (o_encryption != 2'd3))
        else $error("ok result with impossible offset or encryption");

endmodule

bind backup_header_parser bhp_checker u_bhp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_status         (o_status),
    .o_version        (o_version),
    .o_compression    (o_compression),
    .o_encryption     (o_encryption),
    .o_payload_offset (o_payload_offset)
);
`default_nettype wire
